[hw/rtl/cbv_pkg.sv]
`timescale 1ns / 1ps
package cbv_pkg;

	localparam int MAX_SIDES_DEF = 8;

	localparam int NRM_W = 16;
	localparam int CRD_W = 22;
	localparam int TOL_W = 16;
	localparam int CFG_W = 32;

	// numerator sum and triple product widths, with headroom for three terms
	localparam int NUM_W = 53;
	localparam int DEN_W = 46;

	// quotient carries one extra fraction bit for rounding
	localparam int QUO_W = CRD_W + 1;

	localparam logic signed [CRD_W-1:0] CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
	localparam logic signed [CRD_W-1:0] CRD_MIN = {1'b1, {(CRD_W-1){1'b0}}};

	localparam logic REG_TOL = 1'b0;
	localparam logic REG_THR = 1'b1;

	typedef struct packed {
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nz;
		logic signed [CRD_W-1:0] dval;
	} plane_t;

endpackage

[hw/rtl/convex_brush_vertices_and_box.sv]
`timescale 1ns / 1ps
// Planes of one brush are taken one word per cycle while busy is low; the word
// flagged last_plane starts the solve and busy stays high until the box word.
// Every triple i<j<k goes through one shared 32x32 multiplier; a triple whose
// triple product is zero or under the threshold is skipped as parallel, any
// other is solved on a 23-step divider and checked against each other plane.
// Results leave as one-cycle strobes on result_valid and cannot be held off;
// vertex words come first and the box word with last_result ends the brush.
module convex_brush_vertices_and_box #(
	parameter int MAX_SIDES = cbv_pkg::MAX_SIDES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [cbv_pkg::NRM_W-1:0]  normal_x,
	input  logic signed [cbv_pkg::NRM_W-1:0]  normal_y,
	input  logic signed [cbv_pkg::NRM_W-1:0]  normal_z,
	input  logic signed [cbv_pkg::CRD_W-1:0]  distance,
	input  logic                              last_plane,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic        [cbv_pkg::CFG_W-1:0]  cfg_data,
	output logic                              result_valid,
	output logic                              result_kind,
	output logic signed [cbv_pkg::CRD_W-1:0]  point_x,
	output logic signed [cbv_pkg::CRD_W-1:0]  point_y,
	output logic signed [cbv_pkg::CRD_W-1:0]  point_z,
	output logic signed [cbv_pkg::CRD_W-1:0]  box_max_x,
	output logic signed [cbv_pkg::CRD_W-1:0]  box_max_y,
	output logic signed [cbv_pkg::CRD_W-1:0]  box_max_z,
	output logic                              plane_overflow,
	output logic                              last_result
);
	import cbv_pkg::*;

	localparam int IDX_W = $clog2(MAX_SIDES);
	localparam int CNT_W = $clog2(MAX_SIDES + 1);
	localparam int E_W   = CNT_W + 1;
	localparam int MOP_W = 32;
	localparam int ACC_W = NUM_W;

	typedef enum logic [18:0] {
		S_IDLE = 19'h00001,
		S_LDA  = 19'h00002,
		S_LDB  = 19'h00004,
		S_LDC  = 19'h00008,
		S_LDD  = 19'h00010,
		S_MUL  = 19'h00020,
		S_MDRN = 19'h00040,
		S_CHK  = 19'h00080,
		S_NUM  = 19'h00100,
		S_NDRN = 19'h00200,
		S_DST  = 19'h00400,
		S_DWT  = 19'h00800,
		S_TSEL = 19'h01000,
		S_TMUL = 19'h02000,
		S_TDRN = 19'h04000,
		S_TCMP = 19'h08000,
		S_EMIT = 19'h10000,
		S_NEXT = 19'h20000,
		S_BOX  = 19'h40000
	} state_t;

	typedef struct packed {
		logic       go;
		logic       first;
		logic       last;
		logic       neg;
		logic       wr_cr;
		logic       wr_den;
		logic [3:0] cr_idx;
	} mop_t;

	function automatic logic signed [NRM_W-1:0] comp(plane_t p, logic [1:0] i);
		case (i)
			2'd0:    comp = p.nx;
			2'd1:    comp = p.ny;
			default: comp = p.nz;
		endcase
	endfunction

	state_t state_q;

	plane_t mem [MAX_SIDES];
	plane_t rd_q;
	logic [IDX_W-1:0] rd_addr;

	logic [TOL_W-1:0] tol_q;
	logic [CFG_W-1:0] thr_q;

	logic [CNT_W-1:0] cnt_q, ta_q, tb_q, tc_q, s_q;
	logic             ovf_q, vf_q;
	logic [4:0]       k_q;
	logic [1:0]       ci_q;

	plane_t pa_q, pb_q, pc_q;
	logic signed [MOP_W-1:0] cr_q [9];
	logic signed [DEN_W-1:0] den_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [CRD_W-1:0] p_q [3];
	logic signed [CRD_W-1:0] bmin_q [3];
	logic signed [CRD_W-1:0] bmax_q [3];

	mop_t                    op_s1;
	logic signed [ACC_W-1:0] prod_s1;

	logic                    rv_q, kind_q, ovo_q, lr_q;
	logic signed [CRD_W-1:0] o_pt_q [3];
	logic signed [CRD_W-1:0] o_mx_q [3];

	logic acc_in, full;
	assign acc_in = start && (state_q == S_IDLE);
	assign full   = cnt_q >= CNT_W'(MAX_SIDES);
	assign busy   = state_q != S_IDLE;

	// operand selection for the shared multiplier
	mop_t                    mop;
	logic signed [MOP_W-1:0] ma, mb;
	logic [1:0]              g, r, i1, i2, j;
	logic [2:0]              h;
	logic                    sec;
	logic [3:0]              cr_rd;
	plane_t                  px, py;
	logic signed [2*MOP_W-1:0] prod;

	always_comb begin
		mop   = '0;
		ma    = '0;
		mb    = '0;
		cr_rd = '0;
		g     = (k_q < 5'd6) ? 2'd0 : ((k_q < 5'd12) ? 2'd1 : 2'd2);
		case (g)
			2'd0:    h = k_q[2:0];
			2'd1:    h = 3'(k_q - 5'd6);
			default: h = 3'(k_q - 5'd12);
		endcase
		r   = h[2:1];
		sec = h[0];
		j   = k_q[1:0];
		case (g)
			2'd0: begin
				px = pb_q;
				py = pc_q;
			end
			2'd1: begin
				px = pc_q;
				py = pa_q;
			end
			default: begin
				px = pa_q;
				py = pb_q;
			end
		endcase
		case (r)
			2'd0: begin
				i1 = 2'd1;
				i2 = 2'd2;
			end
			2'd1: begin
				i1 = 2'd2;
				i2 = 2'd0;
			end
			default: begin
				i1 = 2'd0;
				i2 = 2'd1;
			end
		endcase
		case (state_q)
			S_MUL: begin
				mop.go = 1'b1;
				if (k_q < 5'd18) begin
					ma           = MOP_W'(comp(px, sec ? i2 : i1));
					mb           = MOP_W'(comp(py, sec ? i1 : i2));
					mop.neg      = sec;
					mop.first    = !sec;
					mop.last     = sec;
					mop.wr_cr    = 1'b1;
					mop.cr_idx   = 4'(g) * 4'd3 + 4'(r);
				end else begin
					cr_rd        = 4'(k_q - 5'd18);
					ma           = MOP_W'(comp(pa_q, 2'(k_q - 5'd18)));
					mb           = cr_q[cr_rd];
					mop.first    = k_q == 5'd18;
					mop.last     = k_q == 5'd20;
					mop.wr_den   = 1'b1;
				end
			end
			S_NUM: begin
				mop.go    = 1'b1;
				cr_rd     = 4'(j) * 4'd3 + 4'(ci_q);
				ma        = cr_q[cr_rd];
				case (j)
					2'd0:    mb = MOP_W'(pa_q.dval);
					2'd1:    mb = MOP_W'(pb_q.dval);
					default: mb = MOP_W'(pc_q.dval);
				endcase
				mop.first = j == 2'd0;
				mop.last  = j == 2'd2;
			end
			S_TMUL: begin
				mop.go    = 1'b1;
				if (j == 2'd3) begin
					ma = MOP_W'(rd_q.dval);
					mb = -MOP_W'(16384);
				end else begin
					ma = MOP_W'(comp(rd_q, j));
					mb = MOP_W'(p_q[j]);
				end
				mop.first = j == 2'd0;
				mop.last  = j == 2'd3;
			end
			default: begin
				mop = '0;
			end
		endcase
		prod = ma * mb;
	end

	always_comb begin
		case (state_q)
			S_LDA:   rd_addr = ta_q[IDX_W-1:0];
			S_LDB:   rd_addr = tb_q[IDX_W-1:0];
			S_LDC:   rd_addr = tc_q[IDX_W-1:0];
			default: rd_addr = s_q[IDX_W-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc_in && !full) begin
			mem[cnt_q[IDX_W-1:0]] <= '{nx: normal_x, ny: normal_y, nz: normal_z, dval: distance};
		end
		rd_q <= mem[rd_addr];
	end

	// multiply stage then accumulate stage
	logic signed [ACC_W-1:0] acc_sum;
	always_comb begin
		acc_sum = (op_s1.first ? '0 : acc_q) + (op_s1.neg ? -prod_s1 : prod_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= mop;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod[ACC_W-1:0];
		if (op_s1.go) begin
			acc_q <= acc_sum;
			if (op_s1.last && op_s1.wr_cr) begin
				cr_q[op_s1.cr_idx] <= acc_sum[MOP_W-1:0];
			end
			if (op_s1.last && op_s1.wr_den) begin
				den_q <= acc_sum[DEN_W-1:0];
			end
		end
	end

	logic                    div_start, div_done;
	logic signed [CRD_W-1:0] div_quot;
	assign div_start = state_q == S_DST;

	cbv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	logic [DEN_W-1:0] den_mag;
	logic             inside_fail;
	assign den_mag     = den_q[DEN_W-1] ? (~den_q + 1'b1) : den_q;
	assign inside_fail = acc_q > $signed(ACC_W'({tol_q, 14'b0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tol_q   <= TOL_W'(3);
			thr_q   <= CFG_W'(4398047);
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			vf_q    <= 1'b0;
			rv_q    <= 1'b0;
			ta_q    <= '0;
			tb_q    <= '0;
			tc_q    <= '0;
			s_q     <= '0;
			k_q     <= '0;
			ci_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				bmin_q[i] <= '0;
				bmax_q[i] <= '0;
			end
		end else begin
			rv_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_TOL: tol_q <= cfg_data[TOL_W-1:0];
					REG_THR: thr_q <= cfg_data;
					default: tol_q <= tol_q;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (!full) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_plane) begin
							ta_q <= CNT_W'(0);
							tb_q <= CNT_W'(1);
							tc_q <= CNT_W'(2);
							if (E_W'(cnt_q) + E_W'(!full) >= E_W'(3)) begin
								state_q <= S_LDA;
							end else begin
								state_q <= S_BOX;
							end
						end
					end
				end
				S_LDA: state_q <= S_LDB;
				S_LDB: begin
					pa_q    <= rd_q;
					state_q <= S_LDC;
				end
				S_LDC: begin
					pb_q    <= rd_q;
					state_q <= S_LDD;
				end
				S_LDD: begin
					pc_q    <= rd_q;
					k_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					k_q <= k_q + 1'b1;
					if (k_q == 5'd20) begin
						state_q <= S_MDRN;
					end
				end
				S_MDRN: state_q <= S_CHK;
				S_CHK: begin
					// zero product is parallel even with a zero threshold
					if (den_q == '0 || den_mag < DEN_W'(thr_q)) begin
						state_q <= S_NEXT;
					end else begin
						ci_q    <= '0;
						k_q     <= '0;
						state_q <= S_NUM;
					end
				end
				S_NUM: begin
					k_q <= k_q + 1'b1;
					if (k_q == 5'd2) begin
						state_q <= S_NDRN;
					end
				end
				S_NDRN: state_q <= S_DST;
				S_DST:  state_q <= S_DWT;
				S_DWT: begin
					if (div_done) begin
						p_q[ci_q] <= div_quot;
						k_q       <= '0;
						if (ci_q == 2'd2) begin
							s_q     <= '0;
							state_q <= S_TSEL;
						end else begin
							ci_q    <= ci_q + 1'b1;
							state_q <= S_NUM;
						end
					end
				end
				S_TSEL: begin
					if (s_q == cnt_q) begin
						state_q <= S_EMIT;
					end else if (s_q == ta_q || s_q == tb_q || s_q == tc_q) begin
						s_q <= s_q + 1'b1;
					end else begin
						k_q     <= '0;
						state_q <= S_TMUL;
					end
				end
				S_TMUL: begin
					k_q <= k_q + 1'b1;
					if (k_q == 5'd3) begin
						state_q <= S_TDRN;
					end
				end
				S_TDRN: state_q <= S_TCMP;
				S_TCMP: begin
					if (inside_fail) begin
						state_q <= S_NEXT;
					end else begin
						s_q     <= s_q + 1'b1;
						state_q <= S_TSEL;
					end
				end
				S_EMIT: begin
					rv_q   <= 1'b1;
					kind_q <= 1'b0;
					ovo_q  <= ovf_q;
					lr_q   <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						o_pt_q[i] <= p_q[i];
						o_mx_q[i] <= '0;
						if (!vf_q || p_q[i] < bmin_q[i]) begin
							bmin_q[i] <= p_q[i];
						end
						if (!vf_q || p_q[i] > bmax_q[i]) begin
							bmax_q[i] <= p_q[i];
						end
					end
					vf_q    <= 1'b1;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (E_W'(tc_q) + E_W'(1) < E_W'(cnt_q)) begin
						tc_q    <= tc_q + 1'b1;
						state_q <= S_LDA;
					end else if (E_W'(tb_q) + E_W'(2) < E_W'(cnt_q)) begin
						tb_q    <= tb_q + 1'b1;
						tc_q    <= CNT_W'(E_W'(tb_q) + E_W'(2));
						state_q <= S_LDA;
					end else if (E_W'(ta_q) + E_W'(3) < E_W'(cnt_q)) begin
						ta_q    <= ta_q + 1'b1;
						tb_q    <= CNT_W'(E_W'(ta_q) + E_W'(2));
						tc_q    <= CNT_W'(E_W'(ta_q) + E_W'(3));
						state_q <= S_LDA;
					end else begin
						state_q <= S_BOX;
					end
				end
				S_BOX: begin
					rv_q   <= 1'b1;
					kind_q <= 1'b1;
					ovo_q  <= ovf_q;
					lr_q   <= 1'b1;
					for (int i = 0; i < 3; i++) begin
						o_pt_q[i] <= bmin_q[i];
						o_mx_q[i] <= bmax_q[i];
						bmin_q[i] <= '0;
						bmax_q[i] <= '0;
					end
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					vf_q    <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid   = rv_q;
	assign result_kind    = kind_q;
	assign point_x        = o_pt_q[0];
	assign point_y        = o_pt_q[1];
	assign point_z        = o_pt_q[2];
	assign box_max_x      = o_mx_q[0];
	assign box_max_y      = o_mx_q[1];
	assign box_max_z      = o_mx_q[2];
	assign plane_overflow = ovo_q;
	assign last_result    = lr_q;

endmodule

[hw/rtl/cbv_div.sv]
`timescale 1ns / 1ps
module cbv_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [cbv_pkg::NUM_W-1:0]    num,
	input  logic signed [cbv_pkg::DEN_W-1:0]    den,
	output logic                                done,
	output logic signed [cbv_pkg::CRD_W-1:0]    quot
);
	import cbv_pkg::*;

	localparam int FRAC_SH = 15;
	localparam int PRE_W   = QUO_W - FRAC_SH;
	localparam int STEP_W  = $clog2(QUO_W + 1);
	localparam int CMP_W   = NUM_W + PRE_W;
	localparam logic [QUO_W-1:0] POS_LIM = QUO_W'((1 << (CRD_W - 1)) - 1);
	localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1 << (CRD_W - 1));

	logic              busy_q, neg_q, done_q;
	logic [DEN_W-1:0]  ud_q, rem_q;
	logic [QUO_W-1:0]  sh_q, quo_q;
	logic [STEP_W-1:0] step_q;
	logic signed [CRD_W-1:0] quot_q;

	logic [NUM_W-1:0] un;
	logic [DEN_W-1:0] ud;
	logic [DEN_W:0]   trial;
	logic             take, sat;
	logic [QUO_W:0]   qr;
	logic [QUO_W-1:0] qh;

	always_comb begin
		un    = num[NUM_W-1] ? (~num + 1'b1) : num;
		ud    = den[DEN_W-1] ? (~den + 1'b1) : den;
		sat   = CMP_W'(un) >= CMP_W'({ud, {PRE_W{1'b0}}});
		trial = {rem_q, sh_q[QUO_W-1]};
		take  = trial >= {1'b0, ud_q};
		qr    = {1'b0, quo_q} + (QUO_W+1)'(1);
		qh    = qr[QUO_W:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				neg_q  <= num[NUM_W-1] ^ den[DEN_W-1];
				ud_q   <= ud;
				rem_q  <= DEN_W'(un >> PRE_W);
				sh_q   <= {un[PRE_W-1:0], {FRAC_SH{1'b0}}};
				quo_q  <= '0;
				step_q <= STEP_W'(QUO_W);
				if (un == '0) begin
					quot_q <= '0;
					done_q <= 1'b1;
				end else if (sat) begin
					quot_q <= (num[NUM_W-1] ^ den[DEN_W-1]) ? CRD_MIN : CRD_MAX;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (step_q != '0) begin
					if (take) begin
						rem_q <= DEN_W'(trial - {1'b0, ud_q});
					end else begin
						rem_q <= trial[DEN_W-1:0];
					end
					quo_q  <= {quo_q[QUO_W-2:0], take};
					sh_q   <= {sh_q[QUO_W-2:0], 1'b0};
					step_q <= step_q - 1'b1;
				end else begin
					// round half up on the extra bit, then clamp
					busy_q <= 1'b0;
					done_q <= 1'b1;
					if (neg_q) begin
						quot_q <= (qh > NEG_LIM) ? CRD_MIN : -$signed(qh[CRD_W-1:0]);
					end else begin
						quot_q <= (qh > POS_LIM) ? CRD_MAX : $signed(qh[CRD_W-1:0]);
					end
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[verif/convex_brush_vertices_and_box_tb.sv]
`timescale 1ns / 1ps
module convex_brush_vertices_and_box_tb;
	import cbv_pkg::*;

	localparam int WATCHDOG_CYCLES = 200000;

	typedef struct packed {
		logic                    kind;
		logic signed [CRD_W-1:0] px;
		logic signed [CRD_W-1:0] py;
		logic signed [CRD_W-1:0] pz;
		logic signed [CRD_W-1:0] mx;
		logic signed [CRD_W-1:0] my;
		logic signed [CRD_W-1:0] mz;
		logic                    ovf;
		logic                    last;
	} brush_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [NRM_W-1:0] normal_x = '0;
	logic signed [NRM_W-1:0] normal_y = '0;
	logic signed [NRM_W-1:0] normal_z = '0;
	logic signed [CRD_W-1:0] distance = '0;
	logic last_plane = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_TOL;
	logic [CFG_W-1:0] cfg_data = '0;
	logic result_valid;
	logic result_kind;
	logic signed [CRD_W-1:0] point_x, point_y, point_z;
	logic signed [CRD_W-1:0] box_max_x, box_max_y, box_max_z;
	logic plane_overflow;
	logic last_result;

	convex_brush_vertices_and_box DUT (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// predictor state
	longint stored_n[MAX_SIDES_DEF][3];
	longint stored_d[MAX_SIDES_DEF];
	int unsigned stored_cnt;
	bit overflow_flag;
	longint unsigned tol_reg = 3;
	longint unsigned thr_reg = 4398047;

	brush_word_t expected_words[$];
	int errors = 0;
	int vertex_words = 0;
	int box_words = 0;
	int planes_sent = 0;
	int idle_cycles = 0;

	function automatic longint round_div(longint num, longint den);
		bit neg;
		longint unsigned un, ud, q0, r0, q;
		neg = (num < 0) != (den < 0);
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		if (un == 0) return 0;
		q0 = un / ud;
		r0 = un % ud;
		if (q0 >= (64'd1 << 21)) q = 64'd1 << 22;
		else q = (q0 << 14) + ((((r0 << 15) / ud) + 1) >> 1);
		if (neg) return q > 2097152 ? -2097152 : -longint'(q);
		return q > 2097151 ? 2097151 : longint'(q);
	endfunction

	task automatic predict_brush();
		brush_word_t w;
		longint bc[3], ca[3], ab[3], p[3], bmin[3], bmax[3];
		longint den, d;
		longint unsigned mag;
		bit found, ok;
		int cnt;
		cnt = stored_cnt;
		found = 0;
		for (int i = 0; i < 3; i++) begin
			bmin[i] = 0;
			bmax[i] = 0;
		end
		for (int a = 0; a < cnt; a++)
			for (int b = a + 1; b < cnt; b++)
				for (int c = b + 1; c < cnt; c++) begin
					bc[0] = stored_n[b][1]*stored_n[c][2] - stored_n[b][2]*stored_n[c][1];
					bc[1] = stored_n[b][2]*stored_n[c][0] - stored_n[b][0]*stored_n[c][2];
					bc[2] = stored_n[b][0]*stored_n[c][1] - stored_n[b][1]*stored_n[c][0];
					ca[0] = stored_n[c][1]*stored_n[a][2] - stored_n[c][2]*stored_n[a][1];
					ca[1] = stored_n[c][2]*stored_n[a][0] - stored_n[c][0]*stored_n[a][2];
					ca[2] = stored_n[c][0]*stored_n[a][1] - stored_n[c][1]*stored_n[a][0];
					ab[0] = stored_n[a][1]*stored_n[b][2] - stored_n[a][2]*stored_n[b][1];
					ab[1] = stored_n[a][2]*stored_n[b][0] - stored_n[a][0]*stored_n[b][2];
					ab[2] = stored_n[a][0]*stored_n[b][1] - stored_n[a][1]*stored_n[b][0];
					den = stored_n[a][0]*bc[0] + stored_n[a][1]*bc[1] + stored_n[a][2]*bc[2];
					mag = den < 0 ? -den : den;
					if (den == 0 || mag < thr_reg) continue;
					for (int i = 0; i < 3; i++)
						p[i] = round_div(bc[i]*stored_d[a] + ca[i]*stored_d[b]
							+ ab[i]*stored_d[c], den);
					ok = 1;
					for (int s = 0; s < cnt; s++) begin
						if (s == a || s == b || s == c) continue;
						d = stored_n[s][0]*p[0] + stored_n[s][1]*p[1] + stored_n[s][2]*p[2]
							- stored_d[s]*16384;
						if (d > longint'(tol_reg) * 16384) ok = 0;
					end
					if (!ok) continue;
					for (int i = 0; i < 3; i++) begin
						if (!found || p[i] < bmin[i]) bmin[i] = p[i];
						if (!found || p[i] > bmax[i]) bmax[i] = p[i];
					end
					found = 1;
					w = '0;
					w.px = CRD_W'(p[0]);
					w.py = CRD_W'(p[1]);
					w.pz = CRD_W'(p[2]);
					w.ovf = overflow_flag;
					expected_words = {expected_words, w};
				end
		w = '0;
		w.kind = 1'b1;
		w.px = CRD_W'(bmin[0]);
		w.py = CRD_W'(bmin[1]);
		w.pz = CRD_W'(bmin[2]);
		w.mx = CRD_W'(bmax[0]);
		w.my = CRD_W'(bmax[1]);
		w.mz = CRD_W'(bmax[2]);
		w.ovf = overflow_flag;
		w.last = 1'b1;
		expected_words = {expected_words, w};
		stored_cnt = 0;
		overflow_flag = 0;
	endtask

	// start stays high into the next word when there is no gap
	task automatic send_plane(input int nx, ny, nz, dval, input bit fin);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		normal_x <= NRM_W'(nx);
		normal_y <= NRM_W'(ny);
		normal_z <= NRM_W'(nz);
		distance <= CRD_W'(dval);
		last_plane <= fin;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (stored_cnt < MAX_SIDES_DEF) begin
			stored_n[stored_cnt][0] = nx;
			stored_n[stored_cnt][1] = ny;
			stored_n[stored_cnt][2] = nz;
			stored_d[stored_cnt] = dval;
			stored_cnt++;
		end else begin
			overflow_flag = 1;
		end
		planes_sent++;
		if (fin) predict_brush();
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TOL) tol_reg = val[TOL_W-1:0];
		else thr_reg = val;
	endtask

	function automatic logic signed [NRM_W-1:0] rand_normal();
		int r;
		r = $urandom_range(0, 32768);
		return NRM_W'(r - 16384);
	endfunction

	function automatic logic signed [CRD_W-1:0] rand_dist();
		case ($urandom_range(0, 3))
			0: return CRD_W'($urandom_range(0, 4194303) - 2097152);
			default: return CRD_W'($urandom_range(0, 16383) - 2048);
		endcase
	endfunction

	// axis-aligned cube planes with one random half-width, then random extra planes
	task automatic send_box(input int extra);
		logic signed [CRD_W-1:0] h;
		h = CRD_W'($urandom_range(1, 8192));
		send_plane(16384, 0, 0, h, 1'b0);
		send_plane(-16384, 0, 0, h, 1'b0);
		send_plane(0, 16384, 0, h, 1'b0);
		send_plane(0, -16384, 0, h, 1'b0);
		send_plane(0, 0, 16384, h, extra == 0);
		if (extra > 0)
			send_plane(0, 0, -16384, h, extra == 1);
		for (int i = 2; i <= extra; i++)
			send_plane(rand_normal(), rand_normal(), rand_normal(), rand_dist(), i == extra);
	endtask

	task automatic test_directed();
		send_plane(16384, 0, 0, 100, 1'b1);
		send_plane(16384, 0, 0, 100, 1'b0);
		send_plane(0, 16384, 0, -100, 1'b1);
		send_plane(16384, 0, 0, 2097151, 1'b0);
		send_plane(0, 16384, 0, -2097152, 1'b0);
		send_plane(0, 0, -16384, 2097151, 1'b1);
		// parallel triple plus a tilted one, so every triple holds two parallel planes
		send_plane(16384, 0, 0, 0, 1'b0);
		send_plane(16384, 0, 0, 5, 1'b0);
		send_plane(-16384, -16384, -16384, -2097152, 1'b0);
		send_plane(1, 0, 0, 2097151, 1'b1);
		send_box(1);
	endtask

	task automatic test_overflow();
		for (int i = 0; i < 10; i++)
			send_plane(rand_normal(), rand_normal(), rand_normal(), rand_dist(), i == 9);
		send_box(3);
		// dropped plane carries the last flag
		for (int i = 0; i < 9; i++)
			send_plane(16384, 0, 0, 0, i == 8);
	endtask

	task automatic test_config_extremes();
		write_reg(REG_THR, 32'd0);
		write_reg(REG_TOL, 32'd0);
		send_plane(16384, 0, 0, 0, 1'b0);
		send_plane(0, 16384, 0, 0, 1'b0);
		send_plane(0, 0, 16384, 0, 1'b0);
		send_plane(16384, 16384, 0, 0, 1'b1);
		send_box(0);
		write_reg(REG_TOL, 32'd65535);
		send_box(2);
		write_reg(REG_THR, 32'hFFFF_FFFF);
		send_box(1);
		write_reg(REG_THR, 32'd4398047);
		write_reg(REG_TOL, 32'd3);
	endtask

	task automatic test_random();
		int sent;
		int n;
		sent = 0;
		while (sent < 260) begin
			if ($urandom_range(0, 9) < 6) begin
				n = $urandom_range(0, 2);
				send_box(n);
				sent += 5 + n;
			end else begin
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++)
					send_plane(rand_normal(), rand_normal(), rand_normal(), rand_dist(),
						i == n - 1);
				sent += n;
			end
			if ($urandom_range(0, 15) == 0) wait_drained();
			if ($urandom_range(0, 30) == 0)
				write_reg(REG_TOL, $urandom_range(0, 64));
		end
	endtask

	// result checker
	always @(posedge clk) begin
		brush_word_t e;
		if (arst_n && result_valid) begin
			if (result_kind) box_words++;
			else vertex_words++;
			if (expected_words.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (result_kind !== e.kind) begin
					$error("result_kind exp %0d got %0d", e.kind, result_kind); errors++;
				end
				if (point_x !== e.px) begin
					$error("point_x exp %0d got %0d", e.px, point_x); errors++;
				end
				if (point_y !== e.py) begin
					$error("point_y exp %0d got %0d", e.py, point_y); errors++;
				end
				if (point_z !== e.pz) begin
					$error("point_z exp %0d got %0d", e.pz, point_z); errors++;
				end
				if (box_max_x !== e.mx) begin
					$error("box_max_x exp %0d got %0d", e.mx, box_max_x); errors++;
				end
				if (box_max_y !== e.my) begin
					$error("box_max_y exp %0d got %0d", e.my, box_max_y); errors++;
				end
				if (box_max_z !== e.mz) begin
					$error("box_max_z exp %0d got %0d", e.mz, box_max_z); errors++;
				end
				if (plane_overflow !== e.ovf) begin
					$error("plane_overflow exp %0d got %0d", e.ovf, plane_overflow); errors++;
				end
				if (last_result !== e.last) begin
					$error("last_result exp %0d got %0d", e.last, last_result); errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("FAIL convex_brush_vertices_and_box");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_config_extremes();
		test_random();
		wait_drained();
		repeat (200) @(posedge clk);
		$display("planes sent %0d, vertex words %0d, box words %0d",
			planes_sent, vertex_words, box_words);
		if (errors == 0 && expected_words.size() == 0)
			$display("PASS convex_brush_vertices_and_box");
		else
			$display("FAIL convex_brush_vertices_and_box");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/cbv_pkg.sv
hw/rtl/cbv_div.sv
hw/rtl/convex_brush_vertices_and_box.sv
verif/convex_brush_vertices_and_box_tb.sv
